// ===== rtl/bbr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and codes of the 5x5 RGB box blur.
// No dependencies; the RTL files refer to it by scoped names, the bench imports it.

package bbr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CH_W   = 8;          // one color sample
  localparam int PIX_W  = 3 * CH_W;
  localparam int DIM_W  = 11;         // image_width / image_height register fields
  localparam int WIN    = 5;          // window side
  localparam int LINES  = WIN - 1;    // line stores

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int OY_W  = $clog2(MAX_HEIGHT);
  // input row runs up to four rows past the frame while draining
  localparam int ROW_W = $clog2(MAX_HEIGHT + WIN);
  localparam int P_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);

  localparam int CSUM_W = CH_W + 3;   // five samples
  localparam int TSUM_W = CH_W + 5;   // twenty-five samples

  // floor(s / 25) == (s * 5243) >> 17 for every s below 2^TSUM_W
  localparam int DIV_MUL    = 5243;
  localparam int DIV_MUL_W  = 13;
  localparam int DIV_SHIFT  = 17;
  localparam int PROD_W     = TSUM_W + DIV_MUL_W;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } csum_t;

  typedef struct packed {
    logic [TSUM_W-1:0] red;
    logic [TSUM_W-1:0] green;
    logic [TSUM_W-1:0] blue;
  } tsum_t;

  typedef struct packed {
    pixel_t px;
    logic   frame_end;
  } result_t;

endpackage

// ===== rtl/bbr_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the box blur: incoming pixel words and blurred result words.
// Depends on bbr_pkg for sample widths.

interface bbr_pixel_if;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [bbr_pkg::CH_W-1:0] in_red;
  logic [bbr_pkg::CH_W-1:0] in_green;
  logic [bbr_pkg::CH_W-1:0] in_blue;

  modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

interface bbr_result_if;
  logic                    valid;
  logic                    ready;
  logic [bbr_pkg::CH_W-1:0] out_red;
  logic [bbr_pkg::CH_W-1:0] out_green;
  logic [bbr_pkg::CH_W-1:0] out_blue;
  logic                    frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

// ===== rtl/box_blur_5x5_rgb.sv =====
`timescale 1ns / 1ps
// Streaming 5x5 box blur on RGB pixels: four line stores, column-sum window, divide by 25.
// Depends on bbr_pkg and on the channel interfaces in bbr_if.sv.
//
//   channel   | kind         | word
//   ----------+--------------+------------------------------------------------
//   pixel     | valid/ready  | opcode, in_red, in_green, in_blue
//   blurred   | valid/ready  | out_red, out_green, out_blue, frame_end
//   cfg_*     | write only   | cfg_index selects image_width / image_height
//
// One pixel word is taken every cycle while pixel.ready is high. The result for the word
// that completes its window passes the stage 1, window, stage 3 and output registers.
// The line stores are one MAX_WIDTH x 96-bit memory, read when a word is taken and
// written from stage 1 with the rows moved down. pixel.ready drops only while the skid
// register holds a word behind a stalled output. Reset clears control and sets 640 x 480;
// line store contents are not cleared, as rows outside the frame are masked by position.

module box_blur_5x5_rgb (
  input  logic                            clk,
  input  logic                            rst,
  bbr_pixel_if.sink                       pixel,
  bbr_result_if.source                    blurred,
  input  logic                            cfg_write,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbr_pkg::DIM_W-1:0]       cfg_data
);

  localparam int WIN   = bbr_pkg::WIN;
  localparam int LINES = bbr_pkg::LINES;

  function automatic logic [bbr_pkg::WD_W-1:0] clamp_w(input logic [bbr_pkg::DIM_W-1:0] v);
    if (v == '0) begin
      return bbr_pkg::WD_W'(1);
    end else if (int'(v) > bbr_pkg::MAX_WIDTH) begin
      return bbr_pkg::WD_W'(bbr_pkg::MAX_WIDTH);
    end else begin
      return bbr_pkg::WD_W'(v);
    end
  endfunction

  function automatic logic [bbr_pkg::HT_W-1:0] clamp_h(input logic [bbr_pkg::DIM_W-1:0] v);
    if (v == '0) begin
      return bbr_pkg::HT_W'(1);
    end else if (int'(v) > bbr_pkg::MAX_HEIGHT) begin
      return bbr_pkg::HT_W'(bbr_pkg::MAX_HEIGHT);
    end else begin
      return bbr_pkg::HT_W'(v);
    end
  endfunction

  function automatic logic [bbr_pkg::CH_W-1:0] div25(input logic [bbr_pkg::TSUM_W-1:0] s);
    logic [bbr_pkg::PROD_W-1:0] prod;
    prod = bbr_pkg::PROD_W'(s) * bbr_pkg::PROD_W'(bbr_pkg::DIV_MUL);
    return bbr_pkg::CH_W'(prod >> bbr_pkg::DIV_SHIFT);
  endfunction

  // frame geometry and raster position
  logic [bbr_pkg::WD_W-1:0]  img_w;
  logic [bbr_pkg::HT_W-1:0]  img_h;
  logic [bbr_pkg::COL_W-1:0] col;
  logic [bbr_pkg::ROW_W-1:0] row;
  logic [bbr_pkg::P_W-1:0]   pcount;
  logic [bbr_pkg::COL_W-1:0] ox;
  logic [bbr_pkg::OY_W-1:0]  oy;

  logic                      en;
  logic                      accept;
  logic                      adv;
  logic                      emit;
  logic                      last_out;
  logic                      col_wrap;
  logic                      ox_wrap;
  logic [bbr_pkg::P_W-1:0]   lag;
  logic [WIN-1:0]            row_mask;
  logic [WIN-1:0]            col_mask;

  // line store
  bbr_pkg::pixel_t [LINES-1:0] line_mem [bbr_pkg::MAX_WIDTH];
  bbr_pkg::pixel_t [LINES-1:0] rd_word;
  bbr_pkg::pixel_t [LINES-1:0] byp_word;
  bbr_pkg::pixel_t [LINES-1:0] lines;
  bbr_pkg::pixel_t [LINES-1:0] wr_word;
  logic                        byp;

  // stage 1: column build
  logic                      s1_v;
  bbr_pkg::pixel_t           s1_px;
  logic [bbr_pkg::COL_W-1:0] s1_addr;
  logic [WIN-1:0]            s1_row_mask;
  logic                      s1_emit;
  logic [WIN-1:0]            s1_col_mask;
  logic                      s1_fe;
  bbr_pkg::pixel_t [WIN-1:0] col_px;
  bbr_pkg::csum_t            csum;

  // window of column sums, index 0 is the newest column
  bbr_pkg::csum_t            win [WIN];

  // stage 2: window sum
  logic                      s2_v;
  logic [WIN-1:0]            s2_col_mask;
  logic                      s2_fe;
  bbr_pkg::tsum_t            tot;

  // stage 3: divide
  logic                      s3_v;
  bbr_pkg::tsum_t            s3_tot;
  logic                      s3_fe;
  bbr_pkg::result_t          up;

  // output and skid registers
  logic                      o_v;
  bbr_pkg::result_t          o_word;
  logic                      sk_v;
  bbr_pkg::result_t          sk_word;

  assign en           = !sk_v;
  assign pixel.ready  = en;
  assign accept       = pixel.valid && en;

  always_comb begin
    // a flush is dropped while pixels of the frame are still expected
    adv      = accept && ((int'(row) >= int'(img_h)) || (pixel.opcode == bbr_pkg::OP_PIXEL));
    col_wrap = int'(col) == int'(img_w) - 1;
    ox_wrap  = int'(ox) == int'(img_w) - 1;
    lag      = bbr_pkg::P_W'(int'(img_w) * 2 + 2);
    emit     = pcount >= lag;
    last_out = emit && ox_wrap && (int'(oy) == int'(img_h) - 1);
    for (int k = 0; k < WIN; k++) begin
      row_mask[k] = (int'(row) >= k) && (int'(row) < int'(img_h) + k);
    end
    col_mask[0] = int'(ox) + 2 < int'(img_w);
    col_mask[1] = int'(ox) + 1 < int'(img_w);
    col_mask[2] = 1'b1;
    col_mask[3] = int'(ox) >= 1;
    col_mask[4] = int'(ox) >= 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w  <= clamp_w(bbr_pkg::DIM_W'(bbr_pkg::RESET_WIDTH));
      img_h  <= clamp_h(bbr_pkg::DIM_W'(bbr_pkg::RESET_HEIGHT));
      col    <= '0;
      row    <= '0;
      pcount <= '0;
      ox     <= '0;
      oy     <= '0;
    end else if (cfg_write) begin
      unique case (bbr_pkg::cfg_reg_t'(cfg_index))
        bbr_pkg::REG_IMAGE_WIDTH:  img_w <= clamp_w(cfg_data);
        bbr_pkg::REG_IMAGE_HEIGHT: img_h <= clamp_h(cfg_data);
      endcase
      // restart the frame
      col    <= '0;
      row    <= '0;
      pcount <= '0;
      ox     <= '0;
      oy     <= '0;
    end else if (adv) begin
      if (last_out) begin
        col    <= '0;
        row    <= '0;
        pcount <= '0;
        ox     <= '0;
        oy     <= '0;
      end else begin
        col    <= col_wrap ? '0 : col + bbr_pkg::COL_W'(1);
        row    <= col_wrap ? row + bbr_pkg::ROW_W'(1) : row;
        pcount <= pcount + bbr_pkg::P_W'(1);
        if (emit) begin
          ox <= ox_wrap ? '0 : ox + bbr_pkg::COL_W'(1);
          oy <= ox_wrap ? oy + bbr_pkg::OY_W'(1) : oy;
        end
      end
    end
  end

  // read at accept, write back from the stage 1 register with every row moved down one line
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word  <= line_mem[col];
      byp_word <= wr_word;
    end
    if (en && s1_v) begin
      line_mem[s1_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px       <= '{red: pixel.in_red, green: pixel.in_green, blue: pixel.in_blue};
      s1_addr     <= col;
      s1_row_mask <= row_mask;
      s1_emit     <= emit;
      s1_col_mask <= col_mask;
      s1_fe       <= last_out;
      s2_col_mask <= s1_col_mask;
      s2_fe       <= s1_fe;
      s3_tot      <= tot;
      s3_fe       <= s2_fe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      byp  <= 1'b0;
    end else if (en) begin
      s1_v <= adv;
      s2_v <= s1_v && s1_emit;
      s3_v <= s2_v;
      // the word read now is being rewritten at this same edge
      byp  <= adv && s1_v && (s1_addr == col);
    end
  end

  always_comb begin
    lines     = byp ? byp_word : rd_word;
    col_px[0] = s1_px;
    for (int k = 1; k < WIN; k++) begin
      col_px[k] = lines[k-1];
    end
    for (int k = 0; k < LINES; k++) begin
      wr_word[k] = col_px[k];
    end
    csum = '0;
    for (int k = 0; k < WIN; k++) begin
      if (s1_row_mask[k]) begin
        csum.red   = csum.red   + bbr_pkg::CSUM_W'(col_px[k].red);
        csum.green = csum.green + bbr_pkg::CSUM_W'(col_px[k].green);
        csum.blue  = csum.blue  + bbr_pkg::CSUM_W'(col_px[k].blue);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_v) begin
      win[0] <= csum;
      for (int j = 1; j < WIN; j++) begin
        win[j] <= win[j-1];
      end
    end
  end

  always_comb begin
    tot = '0;
    for (int j = 0; j < WIN; j++) begin
      if (s2_col_mask[j]) begin
        tot.red   = tot.red   + bbr_pkg::TSUM_W'(win[j].red);
        tot.green = tot.green + bbr_pkg::TSUM_W'(win[j].green);
        tot.blue  = tot.blue  + bbr_pkg::TSUM_W'(win[j].blue);
      end
    end
  end

  always_comb begin
    up.px.red    = div25(s3_tot.red);
    up.px.green  = div25(s3_tot.green);
    up.px.blue   = div25(s3_tot.blue);
    up.frame_end = s3_fe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v  <= 1'b0;
      sk_v <= 1'b0;
    end else if (o_v && !blurred.ready) begin
      // output stalled: park the incoming word
      if (en && s3_v) begin
        sk_v <= 1'b1;
      end
    end else if (sk_v) begin
      o_v  <= 1'b1;
      sk_v <= 1'b0;
    end else begin
      o_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_v && !blurred.ready) begin
      if (en && s3_v) begin
        sk_word <= up;
      end
    end else if (sk_v) begin
      o_word <= sk_word;
    end else begin
      o_word <= up;
    end
  end

  assign blurred.valid     = o_v;
  assign blurred.out_red   = o_word.px.red;
  assign blurred.out_green = o_word.px.green;
  assign blurred.out_blue  = o_word.px.blue;
  assign blurred.frame_end = o_word.frame_end;

endmodule

// ===== rtl/bbr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the box blur handshakes and skid behavior, bound to the top level.
// Depends on bbr_pkg and box_blur_5x5_rgb.

module bbr_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [bbr_pkg::CH_W-1:0] out_red,
  input logic [bbr_pkg::CH_W-1:0] out_green,
  input logic [bbr_pkg::CH_W-1:0] out_blue,
  input logic                     frame_end
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({out_red, out_green, out_blue, frame_end}))
    else $error("result word changed while stalled");

  // input side closes only behind a stalled output
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("pixel ready dropped without an output stall");

  // a parked word implies a word on show
  a_skid_shown: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input closed with no result word shown");

  // one taken result frees the skid at once
  a_ready_back: assert property (@(posedge clk) disable iff (rst)
    !in_ready && out_ready |=> in_ready)
    else $error("pixel ready not restored after output drained");

  // in_valid is carried for waveform context
  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind box_blur_5x5_rgb bbr_checker u_bbr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel.valid),
  .in_ready  (pixel.ready),
  .out_valid (blurred.valid),
  .out_ready (blurred.ready),
  .out_red   (blurred.out_red),
  .out_green (blurred.out_green),
  .out_blue  (blurred.out_blue),
  .frame_end (blurred.frame_end)
);

// ===== bench/box_blur_5x5_rgb_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the 5x5 RGB box blur: drives pixel words, predicts each blurred word.
// Depends on bbr_pkg, the channel interfaces in bbr_if.sv and the box_blur_5x5_rgb top.

module box_blur_5x5_rgb_tb;
  import bbr_pkg::*;

  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int REPORT_LIMIT  = 10;
  localparam int LINE_SLOTS    = 8;
  localparam int WIN_AREA      = WIN * WIN;
  localparam int HALF          = WIN / 2;

  typedef struct packed {
    opcode_t op;
    pixel_t  px;
  } pixel_word_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data  = '0;

  bbr_pixel_if  pix_ch ();
  bbr_result_if blur_ch ();

  box_blur_5x5_rgb i_dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pix_ch),
    .blurred   (blur_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Blur predictor state: frame size, raster position and recent rows
  int      img_w   = RESET_WIDTH;
  int      img_h   = RESET_HEIGHT;
  int      col_pos = 0;
  int      row_pos = 0;
  pixel_t  line_mem [LINE_SLOTS][MAX_WIDTH];
  result_t blur_expected [$];

  pixel_word_t word_queue [$];
  pixel_word_t next_word;
  result_t     seen_word;
  result_t     want_word;
  int          words_queued = 0;
  int          words_taken  = 0;
  int          fed          = 0;
  int          mismatches   = 0;
  int          cycle_count  = 0;
  int          src_gap      = 0;
  int          sink_gap     = 0;
  logic        pix_taken    = 1'b0;
  bit          no_idle      = 1'b0;

  function automatic void blur_config(cfg_reg_t idx, logic [DIM_W-1:0] value);
    int dim;
    dim = (value == 0) ? 1 : int'(value);
    if (idx == REG_IMAGE_WIDTH) begin
      img_w = (dim > MAX_WIDTH) ? MAX_WIDTH : dim;
    end else begin
      img_h = (dim > MAX_HEIGHT) ? MAX_HEIGHT : dim;
    end
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void blur_step(opcode_t op, pixel_t px);
    int c, r, p, q, oy, ox, y, x, dy, dx;
    int sum_r, sum_g, sum_b;
    pixel_t  nb;
    result_t res;
    c = col_pos;
    r = row_pos;
    if (r < img_h) begin
      // drop flush words while the frame still expects pixels
      if (op == OP_FLUSH) return;
      line_mem[r % LINE_SLOTS][c] = px;
    end
    c++;
    if (c >= img_w) begin
      c = 0;
      r++;
    end
    col_pos = c;
    row_pos = r;
    p = r * img_w + c - 1;
    if (p < 2 * img_w + 2) return;
    q  = p - (2 * img_w + 2);
    oy = q / img_w;
    ox = q % img_w;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (dy = -HALF; dy <= HALF; dy++) begin
      y = oy + dy;
      if (y < 0 || y >= img_h) continue;
      for (dx = -HALF; dx <= HALF; dx++) begin
        x = ox + dx;
        if (x < 0 || x >= img_w) continue;
        nb = line_mem[y % LINE_SLOTS][x];
        sum_r += nb.red;
        sum_g += nb.green;
        sum_b += nb.blue;
      end
    end
    res.px.red    = 8'(sum_r / WIN_AREA);
    res.px.green  = 8'(sum_g / WIN_AREA);
    res.px.blue   = 8'(sum_b / WIN_AREA);
    res.frame_end = (q == img_w * img_h - 1);
    if (res.frame_end) begin
      col_pos = 0;
      row_pos = 0;
    end
    blur_expected.push_back(res);
  endfunction

  function automatic pixel_t any_pixel();
    logic [PIX_W-1:0] bits;
    bits = $urandom;
    case ($urandom_range(0, 7))
      0: bits = '1;
      1: bits = '0;
      default: ;
    endcase
    return bits;
  endfunction

  task automatic push_word(opcode_t op, pixel_t px);
    pixel_word_t w;
    w.op = op;
    w.px = px;
    word_queue.push_back(w);
    words_queued++;
  endtask

  // A frame and its drain, maybe cut short; noisy adds stray flushes and pixels in the drain
  task automatic queue_frame(bit noisy, bit cut_short);
    int total, stop, n;
    total = img_w * img_h;
    stop  = cut_short ? $urandom_range(1, total + 2 * img_w + 1) : total + 2 * img_w + 2;
    for (n = 0; n < stop; n++) begin
      if (n < total) begin
        if (noisy && $urandom_range(0, 9) == 0) push_word(OP_FLUSH, any_pixel());
        push_word(OP_PIXEL, any_pixel());
      end else begin
        push_word((noisy && $urandom_range(0, 3) == 0) ? OP_PIXEL : OP_FLUSH, any_pixel());
      end
      fed++;
    end
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || blur_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [DIM_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    blur_config(idx, value);
  endtask

  task automatic report_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
               $time, what, want.px.red, want.px.green, want.px.blue, want.frame_end,
               got.px.red, got.px.green, got.px.blue, got.frame_end);
    end
  endtask

  // Pixel driver: hold a word until taken, otherwise advance or idle a burst
  always @(negedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (pix_ch.valid && !pix_taken) begin
    end else if (src_gap > 0) begin
      pix_ch.valid <= 1'b0;
      src_gap      <= src_gap - 1;
    end else if (word_queue.size() > 0 && !no_idle && $urandom_range(0, 5) == 0) begin
      pix_ch.valid <= 1'b0;
      src_gap      <= $urandom_range(0, 3);
    end else if (word_queue.size() > 0) begin
      next_word       = word_queue.pop_front();
      pix_ch.valid    <= 1'b1;
      pix_ch.opcode   <= next_word.op;
      pix_ch.in_red   <= next_word.px.red;
      pix_ch.in_green <= next_word.px.green;
      pix_ch.in_blue  <= next_word.px.blue;
    end else begin
      pix_ch.valid <= 1'b0;
    end
  end

  // Result receiver: stall in bursts
  always @(negedge clk) begin
    if (rst) begin
      blur_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      blur_ch.ready <= 1'b0;
      sink_gap      <= sink_gap - 1;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      blur_ch.ready <= 1'b0;
      sink_gap      <= $urandom_range(0, 3);
    end else begin
      blur_ch.ready <= 1'b1;
    end
  end

  // Predict on every taken pixel word, then check every taken result word
  always @(posedge clk) begin
    pix_taken <= !rst && pix_ch.valid && pix_ch.ready;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      blur_step(opcode_t'(pix_ch.opcode),
                pixel_t'({pix_ch.in_red, pix_ch.in_green, pix_ch.in_blue}));
      words_taken++;
    end
    if (!rst && blur_ch.valid && blur_ch.ready) begin
      seen_word.px.red    = blur_ch.out_red;
      seen_word.px.green  = blur_ch.out_green;
      seen_word.px.blue   = blur_ch.out_blue;
      seen_word.frame_end = blur_ch.frame_end;
      if (blur_expected.size() == 0) begin
        report_mismatch("unexpected blurred word", '0, seen_word);
      end else begin
        want_word = blur_expected.pop_front();
        if (seen_word.px.red !== want_word.px.red ||
            seen_word.px.green !== want_word.px.green ||
            seen_word.px.blue !== want_word.px.blue ||
            seen_word.frame_end !== want_word.frame_end) begin
          report_mismatch("blurred word mismatch", want_word, seen_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int n, frames, f, raw_w, raw_h;
    pix_ch.valid    = 1'b0;
    pix_ch.opcode   = OP_PIXEL;
    pix_ch.in_red   = '0;
    pix_ch.in_green = '0;
    pix_ch.in_blue  = '0;
    blur_ch.ready   = 1'b0;
    for (n = 0; n < LINE_SLOTS * MAX_WIDTH; n++) line_mem[n / MAX_WIDTH][n % MAX_WIDTH] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset size: run just past the first window, then cut the frame with a write
    for (n = 0; n < 2 * img_w + 12; n++) push_word(OP_PIXEL, any_pixel());
    wait_drained();

    // 3 x 2 frame with distinct channels, flushes in the frame, a pixel in the drain
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    push_word(OP_FLUSH, 24'h000000);
    push_word(OP_PIXEL, 24'hFFFFFF);
    push_word(OP_PIXEL, 24'h000000);
    push_word(OP_PIXEL, 24'hFF0000);
    push_word(OP_FLUSH, 24'hFFFFFF);
    push_word(OP_PIXEL, 24'h00FF00);
    push_word(OP_PIXEL, 24'h0000FF);
    push_word(OP_PIXEL, 24'h804020);
    for (n = 0; n < 8; n++) push_word((n == 3) ? OP_PIXEL : OP_FLUSH, 24'hFFFFFF);
    wait_drained();

    // Zero in both registers means a 1 x 1 frame
    write_reg(REG_IMAGE_WIDTH, 11'd0);
    write_reg(REG_IMAGE_HEIGHT, 11'd0);
    push_word(OP_PIXEL, 24'hFFFFFF);
    push_word(OP_PIXEL, 24'hFFFFFF);
    for (n = 0; n < 3; n++) push_word(OP_FLUSH, 24'h000000);
    wait_drained();

    // Oversized registers saturate at the maximum
    write_reg(REG_IMAGE_WIDTH, 11'd2047);
    write_reg(REG_IMAGE_HEIGHT, 11'd1);
    queue_frame(1'b0, 1'b0);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 11'd1);
    write_reg(REG_IMAGE_HEIGHT, 11'd2047);
    queue_frame(1'b1, 1'b0);
    wait_drained();

    fed = 0;
    while (fed < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: raw_w = $urandom_range(1, 6);
        6, 7:             raw_w = $urandom_range(7, 24);
        8:                raw_w = 0;
        default:          raw_w = $urandom_range(25, 48);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: raw_h = $urandom_range(1, 8);
        7:                   raw_h = 0;
        default:             raw_h = $urandom_range(9, 20);
      endcase
      if (raw_w > 24) raw_h = $urandom_range(1, 3);
      no_idle = (fed > RANDOM_ITEMS * 4 / 5) || ($urandom_range(0, 3) == 0);
      write_reg(REG_IMAGE_WIDTH, 11'(raw_w));
      write_reg(REG_IMAGE_HEIGHT, 11'(raw_h));
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        queue_frame($urandom_range(0, 2) == 0, (f == frames - 1) && ($urandom_range(0, 4) == 0));
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
